// ===== hdl/u2agf_pkg.sv =====
// Shared types, fold table and decode helpers for the UTF-8 glyph fold block.
`timescale 1ns / 1ps
`default_nettype none

package u2agf_pkg;

    localparam int FOLD_N = 22;

    typedef logic [20:0]     t_code;
    typedef logic [6:0][7:0] t_text;
    typedef logic [4:0]      t_idx;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic step;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hold;
        logic seg_end;
        logic final_seg;
    } t_sts;

    typedef struct packed {
        logic hit;
        t_idx idx;
    } t_find;

    localparam t_code FOLD_CODE [FOLD_N] = '{
        21'h000B7, 21'h02014, 21'h02500, 21'h02026, 21'h02190, 21'h02191,
        21'h02192, 21'h02193, 21'h02194, 21'h021B3, 21'h023F3, 21'h0258C,
        21'h025A3, 21'h025B6, 21'h025BC, 21'h02699, 21'h026A0, 21'h02713,
        21'h02717, 21'h0276F, 21'h1F4CE, 21'h1F5BC
    };

    // text is left-justified: first character in element 6
    localparam t_text FOLD_TEXT [FOLD_N] = '{
        {".", 48'h0},    {"-", 48'h0},    {"-", 48'h0},    {"...", 32'h0},
        {"<-", 40'h0},   {"^", 48'h0},    {"->", 40'h0},   {"v", 48'h0},
        {"<>", 40'h0},   {">", 48'h0},    {"[~]", 32'h0},  {"|", 48'h0},
        {"#", 48'h0},    {">", 48'h0},    {"v", 48'h0},    {"*", 48'h0},
        {"!", 48'h0},    {"+", 48'h0},    {"x", 48'h0},    {">", 48'h0},
        {"[file]", 8'h0}, "[image]"
    };

    localparam logic [2:0] FOLD_LEN [FOLD_N] = '{
        3'd1, 3'd1, 3'd1, 3'd3, 3'd2, 3'd1, 3'd2, 3'd1, 3'd2, 3'd1, 3'd3,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd6, 3'd7
    };

    // sequence length implied by a lead byte
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        if (b >= 8'hF0) begin
            len = 3'd4;
        end else if (b >= 8'hE0) begin
            len = 3'd3;
        end else if (b >= 8'hC0) begin
            len = 3'd2;
        end else begin
            len = 3'd1;
        end
        return len;
    endfunction

    // match a code point against every table entry in parallel
    function automatic t_find fold_find(input t_code cp);
        t_find f;
        f.hit = 1'b0;
        f.idx = '0;
        for (int i = 0; i < FOLD_N; i++) begin
            if (!f.hit && FOLD_CODE[i] == cp) begin
                f.hit = 1'b1;
                f.idx = t_idx'(i);
            end
        end
        return f;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/u2agf_if.sv =====
// Valid/ready channel interfaces for text words in and folded words out.
`timescale 1ns / 1ps
`default_nettype none

interface u2agf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface u2agf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       out_end_of_text;

    modport source (output valid, output out_byte, output last_of_run,
                    output out_end_of_text, input ready);
    modport sink   (input valid, input out_byte, input last_of_run,
                    input out_end_of_text, output ready);
endinterface

`default_nettype wire

// ===== hdl/u2agf_ctrl.sv =====
// Sequencer for the glyph fold: accept, segment scan and byte emission.
`timescale 1ns / 1ps
`default_nettype none

module u2agf_ctrl import u2agf_pkg::*; (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire       i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} t_state;

    t_state r_state, n_state;
    logic   w_in_acc, w_out_acc, w_run_done;

    // take a new word when idle or as the last word of a run leaves
    always_comb begin
        w_out_acc   = (r_state == ST_EMIT) && i_out_ready;
        w_run_done  = w_out_acc && i_sts.seg_end && i_sts.final_seg;
        o_in_ready  = (r_state == ST_IDLE) || w_run_done;
        o_out_valid = (r_state == ST_EMIT);
        w_in_acc    = i_in_valid && o_in_ready;
        o_cmd.load  = w_in_acc;
        o_cmd.scan  = (r_state == ST_SCAN);
        o_cmd.step  = w_out_acc;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && !i_sts.hold) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_acc && i_sts.seg_end) begin
                    if (!i_sts.final_seg) begin
                        n_state = ST_SCAN;
                    end else if (w_in_acc && !i_sts.hold) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/u2agf_dp.sv =====
// Datapath: mode register, sequence buffer, segment decode and output select.
`timescale 1ns / 1ps
`default_nettype none

module u2agf_dp import u2agf_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire        i_cfg_wdata,
    input  wire  [7:0] i_in_byte,
    input  wire        i_end_of_text,
    input  wire  t_cmd i_cmd,
    output t_sts       o_sts,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_out_end_of_text
);

    // control registers
    logic       r_fold;
    logic [1:0] r_pcnt;
    logic [2:0] r_slen;

    // payload registers
    logic [7:0] r_pend [3];
    logic [7:0] r_buf  [4];
    logic [2:0] r_n;
    logic       r_eot;
    logic       r_rawall;
    logic [2:0] r_ptr;
    logic       r_rep;
    t_idx       r_idx;
    logic [2:0] r_cnt;
    logic [2:0] r_adv;
    logic       r_final;
    logic [2:0] r_k;

    logic [2:0] w_n_cur, w_need;
    logic       w_hold;

    // decide whether the incoming word only extends the buffer
    always_comb begin
        w_n_cur = {1'b0, r_pcnt} + 3'd1;
        w_need  = (r_pcnt == 2'd0) ? lead_len(i_in_byte) : r_slen;
        w_hold  = r_fold && (w_n_cur < w_need) && !i_end_of_text;
    end

    logic [7:0] w_b, w_c1, w_c2, w_c3;
    logic [2:0] w_len, w_p1, w_p2, w_p3;
    logic [3:0] w_end;
    t_code      w_cp;
    t_find      w_find;
    logic       w_rep;
    logic [2:0] w_cnt, w_adv;
    logic       w_final;
    logic [3:0] w_stop;

    // decode the segment that starts at the scan pointer
    always_comb begin
        w_p1   = r_ptr + 3'd1;
        w_p2   = r_ptr + 3'd2;
        w_p3   = r_ptr + 3'd3;
        w_b    = r_buf[r_ptr[1:0]];
        w_c1   = r_buf[w_p1[1:0]];
        w_c2   = r_buf[w_p2[1:0]];
        w_c3   = r_buf[w_p3[1:0]];
        w_len  = lead_len(w_b);
        w_end  = {1'b0, r_ptr} + {1'b0, w_len};
        case (w_len)
            3'd2:    w_cp = {10'h0, w_b[4:0], w_c1[5:0]};
            3'd3:    w_cp = {5'h0, w_b[3:0], w_c1[5:0], w_c2[5:0]};
            default: w_cp = {w_b[2:0], w_c1[5:0], w_c2[5:0], w_c3[5:0]};
        endcase
        w_find = fold_find(w_cp);
        w_rep  = 1'b0;
        if (r_rawall) begin
            w_adv = r_n;
            w_cnt = r_n;
        end else if (w_b < 8'hC0 || w_end > {1'b0, r_n}) begin
            // ASCII, stray continuation, or a sequence cut short by the end
            w_adv = 3'd1;
            w_cnt = 3'd1;
        end else if (w_find.hit) begin
            w_rep = 1'b1;
            w_adv = w_len;
            w_cnt = FOLD_LEN[w_find.idx];
        end else begin
            w_adv = w_len;
            w_cnt = w_len;
        end
        w_stop  = {1'b0, r_ptr} + {1'b0, w_adv};
        w_final = (w_stop == {1'b0, r_n});
    end

    // hold mode and buffer bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold <= 1'b0;
            r_pcnt <= 2'd0;
            r_slen <= 3'd0;
        end else begin
            if (i_cfg_we) r_fold <= i_cfg_wdata;
            if (i_cmd.load) begin
                if (w_hold) begin
                    r_pcnt <= r_pcnt + 2'd1;
                    r_slen <= w_need;
                end else begin
                    r_pcnt <= 2'd0;
                    r_slen <= 3'd0;
                end
            end
        end
    end

    // capture words, latch segments, advance through them
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_rep   <= w_rep;
            r_idx   <= w_find.idx;
            r_cnt   <= w_cnt;
            r_adv   <= w_adv;
            r_final <= w_final;
            r_k     <= 3'd0;
        end
        if (i_cmd.step && !o_sts.seg_end) begin
            r_k <= r_k + 3'd1;
        end
        // a word taken as the run ends restarts the pointer instead
        if (i_cmd.step && o_sts.seg_end && !i_cmd.load) begin
            r_ptr <= r_ptr + r_adv;
        end
        if (i_cmd.load) begin
            if (w_hold) begin
                r_pend[r_pcnt] <= i_in_byte;
            end else begin
                for (int k = 0; k < 3; k++) begin
                    r_buf[k] <= (r_pcnt == 2'(k)) ? i_in_byte : r_pend[k];
                end
                r_buf[3]       <= i_in_byte;
                r_n            <= w_n_cur;
                r_eot          <= i_end_of_text;
                r_rawall       <= !r_fold;
                r_ptr          <= 3'd0;
            end
        end
    end

    t_text      w_txt;
    logic [2:0] w_rawpos, w_chr;

    // select the outgoing word
    always_comb begin
        w_txt    = FOLD_TEXT[r_idx];
        w_chr    = 3'd6 - r_k;
        w_rawpos = r_ptr + r_k;
        o_out_byte = r_rep ? w_txt[w_chr] : r_buf[w_rawpos[1:0]];
        o_sts.hold      = w_hold;
        o_sts.seg_end   = (r_k == r_cnt - 3'd1);
        o_sts.final_seg = r_final;
        o_last_of_run     = o_sts.seg_end && r_final;
        o_out_end_of_text = o_sts.seg_end && r_final && r_eot;
    end

endmodule

`default_nettype wire

// ===== hdl/utf8_to_ascii_glyph_fold.sv =====
// Top level of the UTF-8 to ASCII glyph fold block.
//
// Text words enter on i_text (valid/ready), one byte each with an end flag;
// folded words leave on o_text, each with last_of_run and out_end_of_text.
// i_cfg_we/i_cfg_wdata set the fold mode; write it only while idle.
// In fold mode, continuation bytes of a multi-byte sequence are buffered
// and accepted at one per cycle with no output. A word that completes a run
// is followed by a scan of each segment in turn, each scan followed by the
// output words of its segment. The next input word is taken in the same
// cycle as the final word of the previous run leaves.
// A stalled receiver holds o_text stable and holds off all new input.
// Synchronous reset clears the sequencer, the buffer count and fold mode.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_ascii_glyph_fold import u2agf_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire          i_cfg_wdata,
    u2agf_in_if.sink     i_text,
    u2agf_out_if.source  o_text
);

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer
    u2agf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_text.valid),
        .o_in_ready  (i_text.ready),
        .o_out_valid (o_text.valid),
        .i_out_ready (o_text.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // datapath
    u2agf_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_byte         (i_text.in_byte),
        .i_end_of_text     (i_text.end_of_text),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .o_out_byte        (o_text.out_byte),
        .o_last_of_run     (o_text.last_of_run),
        .o_out_end_of_text (o_text.out_end_of_text)
    );

endmodule

`default_nettype wire

// ===== hdl/u2agf_chk.sv =====
// Port-level checks for the glyph fold block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module u2agf_chk (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_ready,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [7:0] i_out_byte,
    input wire       i_last_of_run,
    input wire       i_out_eot
);

    // a stalled word stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped under stall");

    // a stalled word keeps its byte
    a_byte_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_byte))
        else $error("output byte changed under stall");

    // end of text only marks the last word of a run
    a_eot_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_eot |-> i_last_of_run)
        else $error("end of text without last of run");

    // input opens during output only as the final word of a run leaves
    a_in_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_in_ready |-> i_out_ready && i_last_of_run)
        else $error("input ready during an unfinished run");

    // a finished run is followed by a gap before new output
    a_run_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_last_of_run |=> !i_out_valid)
        else $error("output valid right after end of run");

endmodule

bind utf8_to_ascii_glyph_fold u2agf_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_text.ready),
    .i_out_valid   (o_text.valid),
    .i_out_ready   (o_text.ready),
    .i_out_byte    (o_text.out_byte),
    .i_last_of_run (o_text.last_of_run),
    .i_out_eot     (o_text.out_end_of_text)
);

`default_nettype wire
